[hw/rtl/heading_hold_turn_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// heading_hold_turn_sequencer assertion macros
// Shorthand for clocked concurrent assertions with a synchronous active-low
// reset. The same-cycle form checks the consequent on the antecedent's edge;
// the next-cycle form checks it on the following clock edge.
// ----------------------------------------------------------------------------
`ifndef HEADING_HOLD_TURN_SEQUENCER_ASSERT_SVH
`define HEADING_HOLD_TURN_SEQUENCER_ASSERT_SVH

// Check cons on the same clock edge as ante.
`define HHTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons on the clock edge after ante.
`define HHTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hhts_pkg.sv]
// ----------------------------------------------------------------------------
// hhts_pkg
// Types, widths and constants shared by the heading-hold turn sequencer.
// ----------------------------------------------------------------------------
package hhts_pkg;

    // field widths
    localparam int YAW_W    = 13;
    localparam int LIDAR_W  = 11;
    localparam int PULSE_W  = 8;
    localparam int SERVO_W  = 8;
    localparam int DRIVE_W  = 9;
    localparam int TURN_W   = 8;
    localparam int TARGET_W = 9;
    localparam int INTEG_W  = 24;
    localparam int TICK_W   = 32;
    localparam int DIFF_W   = 15;
    localparam int ERR_W    = 9;
    localparam int CORR_W   = 7;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_OBSTACLE = 2'd0,
        REG_STOP     = 2'd1,
        REG_CCW      = 2'd2,
        REG_LAP      = 2'd3
    } t_reg_idx;

    localparam logic [LIDAR_W-1:0] OBSTACLE_RST = 11'd60;
    localparam logic [7:0]         STOP_RST     = 8'd80;
    localparam logic               CCW_RST      = 1'b0;
    localparam logic [TURN_W-1:0]  LAP_RST      = 8'd12;

    // default distance scale
    localparam int TICKS_PER_UNIT_DEF = 45;
    localparam int TURN_GAP_UNITS     = 100;

    // servo and drive levels
    localparam logic [SERVO_W-1:0] SERVO_STRAIGHT = 8'd90;
    localparam logic [SERVO_W-1:0] SERVO_CW       = 8'd132;
    localparam logic [SERVO_W-1:0] SERVO_CCW      = 8'd48;
    localparam logic [DRIVE_W-1:0] DRIVE_CRUISE   = 9'd275;
    localparam logic [DRIVE_W-1:0] DRIVE_TURN     = 9'd225;
    localparam logic [DRIVE_W-1:0] DRIVE_STOP     = 9'd0;

    // heading constants, sixteenths of a degree where noted
    localparam logic signed [DIFF_W-1:0] TURN_TOL16 = 15'sd96;
    localparam logic signed [DIFF_W-1:0] QUARTER16  = 15'sd1440;
    localparam logic signed [10:0]       FULL_DEG   = 11'sd360;
    localparam logic signed [10:0]       HALF_DEG   = 11'sd180;

    // PI gains, Q16
    localparam logic [17:0] KP_POS_Q16 = 18'd150733;
    localparam logic [17:0] KP_NEG_Q16 = 18'd144179;
    localparam logic [7:0]  KI_Q16     = 8'd66;
    localparam logic signed [CORR_W-1:0] CORR_MAX = 7'sd45;
    localparam logic signed [32:0] CORR_LIM_Q16 = 33'sd3014656; // 46 << 16

    typedef struct packed {
        logic [YAW_W-1:0]   yaw_heading;
        logic [LIDAR_W-1:0] lidar_range;
        logic [PULSE_W-1:0] wheel_pulses;
    } t_in_item;

    typedef struct packed {
        logic [SERVO_W-1:0] servo_angle;
        logic [DRIVE_W-1:0] motor_level;
        logic               halted;
        logic               in_turn;
        logic [TURN_W-1:0]  turns_done;
    } t_out_item;

    typedef struct packed {
        logic [LIDAR_W-1:0] obstacle_threshold;
        logic [7:0]         stop_distance;
        logic               turn_ccw;
        logic [TURN_W-1:0]  lap_turns;
    } t_cfg;

endpackage

[hw/rtl/hhts_apb_regs.sv]
// ----------------------------------------------------------------------------
// hhts_apb_regs
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module hhts_apb_regs
    import hhts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_threshold <= OBSTACLE_RST;
            r_cfg.stop_distance      <= STOP_RST;
            r_cfg.turn_ccw           <= CCW_RST;
            r_cfg.lap_turns          <= LAP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_OBSTACLE: r_cfg.obstacle_threshold <= pwdata[LIDAR_W-1:0];
                REG_STOP:     r_cfg.stop_distance      <= pwdata[7:0];
                REG_CCW:      r_cfg.turn_ccw           <= pwdata[0];
                REG_LAP:      r_cfg.lap_turns          <= pwdata[TURN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_OBSTACLE: prdata = APB_DATA_W'(r_cfg.obstacle_threshold);
            REG_STOP:     prdata = APB_DATA_W'(r_cfg.stop_distance);
            REG_CCW:      prdata = APB_DATA_W'(r_cfg.turn_ccw);
            REG_LAP:      prdata = APB_DATA_W'(r_cfg.lap_turns);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/hhts_target.sv]
// ----------------------------------------------------------------------------
// hhts_target
// New target heading for a 90 degree turn, wrapped, and snapped to a quadrant when within 15 degrees of it.
// ----------------------------------------------------------------------------
module hhts_target
    import hhts_pkg::*;
(
    input  logic [YAW_W-1:0]    i_yaw,
    input  logic                i_ccw,
    output logic [TARGET_W-1:0] o_target
);

    logic signed [DIFF_W-1:0] raw;
    logic        [DIFF_W-1:0] mag;
    logic        [9:0]        quo;
    logic signed [10:0]       deg;
    logic signed [10:0]       wrapped;

    always_comb begin
        // turned heading in sixteenths, then whole degrees toward zero
        raw = i_ccw ? $signed({2'b00, i_yaw}) - QUARTER16
                    : $signed({2'b00, i_yaw}) + QUARTER16;
        mag = raw[DIFF_W-1] ? DIFF_W'(-raw) : DIFF_W'(raw);
        quo = mag[13:4];
        deg = raw[DIFF_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

        wrapped = deg;
        if (deg > FULL_DEG) begin
            wrapped = deg - FULL_DEG;
        end else if (deg < 11'sd0) begin
            wrapped = deg + FULL_DEG;
        end

        // snap to a quadrant when within 15 degrees of it
        if (wrapped > 11'sd75 && wrapped < 11'sd105) begin
            o_target = 9'd90;
        end else if (wrapped > 11'sd165 && wrapped < 11'sd195) begin
            o_target = 9'd180;
        end else if (wrapped > 11'sd255 && wrapped < 11'sd285) begin
            o_target = 9'd270;
        end else if (wrapped > 11'sd345 || wrapped < 11'sd15) begin
            o_target = 9'd0;
        end else begin
            o_target = wrapped[TARGET_W-1:0];
        end
    end

endmodule

[hw/rtl/hhts_steer.sv]
// ----------------------------------------------------------------------------
// hhts_steer
// PI heading hold: rounded error, saturating integral, clamped servo angle.
// ----------------------------------------------------------------------------
module hhts_steer
    import hhts_pkg::*;
(
    input  logic signed [DIFF_W-1:0]  i_diff,
    input  logic signed [INTEG_W-1:0] i_integ,
    output logic signed [INTEG_W-1:0] o_integ,
    output logic        [SERVO_W-1:0] o_servo
);

    logic        [DIFF_W-1:0]  mag;
    logic        [9:0]         quo;
    logic signed [10:0]        err_r;
    logic signed [10:0]        err_w;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ;
    logic        [17:0]        kp;
    logic signed [27:0]        p_term;
    logic signed [31:0]        i_term;
    logic signed [32:0]        corr_q16;
    logic        [32:0]        corr_mag;
    logic signed [CORR_W-1:0]  corr;
    logic signed [8:0]         servo_s;

    always_comb begin
        // error in whole degrees, halves away from zero
        mag   = i_diff[DIFF_W-1] ? DIFF_W'(-i_diff) : DIFF_W'(i_diff);
        quo   = 10'((mag + DIFF_W'(8)) >> 4);
        err_r = i_diff[DIFF_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        err_w = err_r;
        if (err_r > HALF_DEG) begin
            err_w = err_r - FULL_DEG;
        end else if (err_r < -HALF_DEG) begin
            err_w = err_r + FULL_DEG;
        end
        err = err_w[ERR_W-1:0];

        // saturating integral
        integ_sum = $signed({i_integ[INTEG_W-1], i_integ}) + (INTEG_W+1)'(err);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ = integ_sum[INTEG_W-1:0];
        end

        kp       = (err > 9'sd0) ? KP_POS_Q16 : KP_NEG_Q16;
        p_term   = err * $signed({1'b0, kp});
        i_term   = integ * $signed(KI_Q16);
        corr_q16 = 33'(p_term) - 33'(i_term);

        // truncate toward zero, clamp
        corr_mag = corr_q16[32] ? 33'(-corr_q16) : 33'(corr_q16);
        if (err == 9'sd0) begin
            corr = '0;
        end else if (corr_q16 >= CORR_LIM_Q16) begin
            corr = CORR_MAX;
        end else if (corr_q16 <= -CORR_LIM_Q16) begin
            corr = -CORR_MAX;
        end else if (corr_q16[32]) begin
            corr = -$signed({1'b0, corr_mag[21:16]});
        end else begin
            corr = $signed({1'b0, corr_mag[21:16]});
        end

        servo_s = $signed({1'b0, SERVO_STRAIGHT}) + 9'(corr);
        o_servo = servo_s[SERVO_W-1:0];
        o_integ = integ;
    end

endmodule

[hw/rtl/heading_hold_turn_sequencer.sv]
// ----------------------------------------------------------------------------
// heading_hold_turn_sequencer: result valid once the accepted item has passed
// the input register, then the state register that doubles as the result.
// Throughput one item per cycle; a stalled result holds the input register.
// Reset (sync, active low) restores control and state registers to defaults; the input payload is not reset.
// ----------------------------------------------------------------------------
module heading_hold_turn_sequencer
    import hhts_pkg::*;
#(
    parameter int TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Distance in units is ticks / TICKS_PER_UNIT, rounded down. Compare
    // tick counts against scaled thresholds instead of dividing.
    localparam int TPU_W  = $clog2(TICKS_PER_UNIT + 1);
    localparam int STOP_W = 8 + TPU_W;
    localparam logic [TICK_W-1:0] LEAVE_TICKS =
        TICK_W'((TURN_GAP_UNITS + 1) * TICKS_PER_UNIT);

    t_cfg cfg;

    // input stage
    logic     r_in_valid;
    t_in_item r_in;
    logic     r_out_valid;
    logic     advance;

    // block state; the state also serves as the result register
    logic                      r_turn_active, n_turn_active;
    logic [TURN_W-1:0]         r_turns,       n_turns;
    logic [TARGET_W-1:0]       r_target,      n_target;
    logic signed [INTEG_W-1:0] r_integ,       n_integ;
    logic [TICK_W-1:0]         r_tick,        n_tick;
    logic [SERVO_W-1:0]        r_servo,       n_servo;
    logic [DRIVE_W-1:0]        r_drive,       n_drive;
    logic                      r_stopped,     n_stopped;
    logic [STOP_W-1:0]         stop_ticks;

    logic [TICK_W:0]           tick_sum;
    logic [TICK_W-1:0]         tick_acc;
    logic signed [DIFF_W-1:0]  diff;
    logic                      turn_end;
    logic [TARGET_W-1:0]       turn_target;
    logic signed [INTEG_W-1:0] steer_integ;
    logic [SERVO_W-1:0]        steer_servo;

    hhts_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hhts_target u_target (
        .i_yaw    (r_in.yaw_heading),
        .i_ccw    (cfg.turn_ccw),
        .o_target (turn_target)
    );

    hhts_steer u_steer (
        .i_diff  (diff),
        .i_integ (r_integ),
        .o_integ (steer_integ),
        .o_servo (steer_servo)
    );

    // Advance the held item whenever the result slot is free or being drained;
    // the input register takes a new item in that same cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Travelled ticks, saturating at the counter's top.
    assign tick_sum = {1'b0, r_tick} + (TICK_W+1)'(r_in.wheel_pulses);
    assign tick_acc = tick_sum[TICK_W] ? '1 : tick_sum[TICK_W-1:0];

    // Stop threshold in ticks, straight from the current setting.
    assign stop_ticks = STOP_W'(cfg.stop_distance) * STOP_W'(TICKS_PER_UNIT);

    // Heading error in sixteenths, no wrap; the turn ends inside +/-6 degrees.
    assign diff     = $signed({2'b00, r_target, 4'b0000}) - $signed({2'b00, r_in.yaw_heading});
    assign turn_end = r_turn_active && (diff <= TURN_TOL16) && (diff >= -TURN_TOL16);

    always_comb begin
        n_turn_active = r_turn_active;
        n_turns       = r_turns;
        n_target      = r_target;
        n_integ       = r_integ;
        n_tick        = r_tick;
        n_servo       = r_servo;
        n_drive       = r_drive;
        n_stopped     = r_stopped;

        // once halted, hold every field and ignore the item
        if (advance && !r_stopped) begin
            n_tick = tick_acc;

            // end of turn
            if (turn_end) begin
                n_servo       = SERVO_STRAIGHT;
                n_drive       = DRIVE_CRUISE;
                n_turn_active = 1'b0;
                n_tick        = '0;
                if (r_turns != '1) begin
                    n_turns = r_turns + TURN_W'(1);
                end
            end

            // obstacle: start a quarter turn, first one needs no run-up
            if (r_in.lidar_range < cfg.obstacle_threshold && !n_turn_active &&
                (n_turns == '0 || n_tick >= LEAVE_TICKS)) begin
                n_servo       = cfg.turn_ccw ? SERVO_CCW : SERVO_CW;
                n_drive       = DRIVE_TURN;
                n_target      = turn_target;
                n_turn_active = 1'b1;
            end

            // halt after the last lap and the stop distance, else steer
            if (n_turns == cfg.lap_turns && n_tick >= TICK_W'(stop_ticks)) begin
                n_servo   = SERVO_STRAIGHT;
                n_drive   = DRIVE_STOP;
                n_stopped = 1'b1;
            end else if (!n_turn_active) begin
                n_servo = steer_servo;
                n_integ = steer_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_active <= 1'b0;
            r_turns       <= '0;
            r_target      <= '0;
            r_integ       <= '0;
            r_tick        <= '0;
            r_servo       <= SERVO_STRAIGHT;
            r_drive       <= DRIVE_CRUISE;
            r_stopped     <= 1'b0;
        end else begin
            r_turn_active <= n_turn_active;
            r_turns       <= n_turns;
            r_target      <= n_target;
            r_integ       <= n_integ;
            r_tick        <= n_tick;
            r_servo       <= n_servo;
            r_drive       <= n_drive;
            r_stopped     <= n_stopped;
        end
    end

    // The state after the last advanced item is the result.
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out_item.servo_angle = r_servo;
        o_out_item.motor_level = r_drive;
        o_out_item.halted      = r_stopped;
        o_out_item.in_turn     = r_turn_active;
        o_out_item.turns_done  = r_turns;
    end

`include "heading_hold_turn_sequencer_assert.svh"

    // halt is permanent
    `HHTS_ASSERT_NEXT(a_halt_sticks, i_clk, i_rst_n, r_stopped, r_stopped, "halt released")
    // drive is zero exactly when halted
    `HHTS_ASSERT_NOW(a_stop_drive, i_clk, i_rst_n, 1'b1, ((r_drive == DRIVE_STOP) == r_stopped), "drive and halt disagree")
    // an active turn drives at turning level unless halted
    `HHTS_ASSERT_NOW(a_turn_drive, i_clk, i_rst_n, (r_turn_active && !r_stopped), (r_drive == DRIVE_TURN), "turn without turn drive")
    // state moves only when an item advances
    `HHTS_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !advance, ($stable(r_turns) && $stable(r_tick) && $stable(r_integ)), "state changed without item")

endmodule
